>>> rtl/qti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qti_pkg;

    localparam int CMD_W   = 2;
    localparam int AXSEL_W = 2;
    localparam int ADDR_W  = 12;
    localparam int VAL_W   = 32;
    localparam int SIZE_W  = 7;
    localparam int CFG_IDX_W = 2;
    localparam int WGT_W   = 17;
    localparam int FRAC_W  = 16;
    localparam int NUM_AXES = 4;

    localparam logic [CMD_W-1:0] CMD_AXIS_WR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TABLE_WR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_GZ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_C  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_K  = 2'd3;

    localparam logic [WGT_W-1:0] WEIGHT_ONE = 17'h10000;

    typedef logic [VAL_W-1:0] t_val;
    typedef logic [WGT_W-1:0] t_wgt;

endpackage
`default_nettype wire

>>> rtl/qti_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface qti_req_if;
    logic                           valid;
    logic                           ready;
    logic [qti_pkg::CMD_W-1:0]      command;
    logic [qti_pkg::AXSEL_W-1:0]    axis_select;
    logic [qti_pkg::ADDR_W-1:0]     address;
    logic signed [qti_pkg::VAL_W-1:0] write_value;
    logic signed [qti_pkg::VAL_W-1:0] coord_z;
    logic signed [qti_pkg::VAL_W-1:0] coord_gz;
    logic signed [qti_pkg::VAL_W-1:0] coord_c;
    logic signed [qti_pkg::VAL_W-1:0] coord_k;

    modport source (
        output valid, command, axis_select, address, write_value,
               coord_z, coord_gz, coord_c, coord_k,
        input  ready
    );
    modport sink (
        input  valid, command, axis_select, address, write_value,
               coord_z, coord_gz, coord_c, coord_k,
        output ready
    );
endinterface
`default_nettype wire

>>> rtl/qti_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface qti_rsp_if;
    logic                             valid;
    logic                             ready;
    logic signed [qti_pkg::VAL_W-1:0] result_value;
    logic                             status;

    modport source (output valid, result_value, status, input ready);
    modport sink (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

>>> rtl/quadrilinear_table_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// A write or no-op request goes to the done state, which registers its response once the
// previous response has been taken. A query runs a linear search of each axis through one
// memory port, a weight divider per axis, a corner fetch and 15 blends.
// One request is processed at a time; a stalled response holds back the next response.
// Reset sets the sizes to 2, 2, 2, 1 and clears control state; memories are not cleared.
module quadrilinear_table_interpolator #(
    parameter int AXIS_POINTS = 64,
    parameter int TABLE_DEPTH = 4096
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [qti_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [qti_pkg::SIZE_W-1:0]        i_cfg_data,
    qti_req_if.sink                          i_req,
    qti_rsp_if.source                        o_rsp
);
    import qti_pkg::*;

    localparam int NW  = $clog2(AXIS_POINTS + 1);
    localparam int IW  = 4 * NW;
    localparam int AXW = $clog2(4 * AXIS_POINTS);
    localparam int TW  = $clog2(TABLE_DEPTH);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_AX_INIT  = 5'd1;
    localparam logic [4:0] S_AX_LO    = 5'd2;
    localparam logic [4:0] S_AX_HI    = 5'd3;
    localparam logic [4:0] S_AX_SRCH  = 5'd4;
    localparam logic [4:0] S_DIV_SET  = 5'd5;
    localparam logic [4:0] S_DIV_WAIT = 5'd6;
    localparam logic [4:0] S_IX0      = 5'd7;
    localparam logic [4:0] S_IX1      = 5'd8;
    localparam logic [4:0] S_IX2      = 5'd9;
    localparam logic [4:0] S_IX3      = 5'd10;
    localparam logic [4:0] S_IX4      = 5'd11;
    localparam logic [4:0] S_FILL     = 5'd12;
    localparam logic [4:0] S_BL_GO    = 5'd13;
    localparam logic [4:0] S_BL_WAIT  = 5'd14;
    localparam logic [4:0] S_DONE     = 5'd15;

    logic [4:0]        r_state;
    logic [SIZE_W-1:0] r_size [NUM_AXES];
    t_val              r_coord [NUM_AXES];
    logic [1:0]        r_axis;
    logic [NW-1:0]     r_pidx;
    logic [NW-1:0]     n_pidx;
    t_val              r_prev;
    t_val              r_hi;
    logic [NW-1:0]     r_cell [NUM_AXES];
    t_wgt              r_w [NUM_AXES];
    logic [IW-1:0]     r_base;
    logic [IW-1:0]     r_sc;
    logic [IW-1:0]     r_sg;
    logic [4:0]        r_fc;
    logic              r_fv;
    logic [3:0]        r_fdly;
    logic              r_foor;
    t_val              r_cq [16];
    logic [3:0]        r_bcnt;
    t_val              r_pres;
    logic              r_pst;
    logic              r_ov;
    t_val              r_ores;
    logic              r_ost;

    t_val              ax_mem [4 * AXIS_POINTS];
    t_val              r_ax_rd;
    t_val              tbl_mem [TABLE_DEPTH];
    t_val              r_tbl_rd;

    logic [NW-1:0]     eff [NUM_AXES];
    logic [NW-1:0]     n_cur;
    logic signed [VAL_W-1:0] v_cur;
    logic              accept;
    logic              ax_we;
    logic              tbl_we;
    logic [AXW-1:0]    ax_waddr;
    logic [AXW-1:0]    ax_raddr;
    logic              srch_stop;
    logic signed [VAL_W:0] d_w;
    logic signed [VAL_W:0] off_w;
    logic              div_start;
    logic              div_done;
    logic [FRAC_W-1:0] div_q;
    logic [IW-1:0]     m_a;
    logic [NW-1:0]     m_b;
    logic [IW-1:0]     m_p;
    logic [IW-1:0]     fidx;
    logic [TW-1:0]     tbl_raddr;
    logic              bl_start;
    logic              bl_done;
    t_val              bl_res;
    logic [1:0]        wsel;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            if (a == NUM_AXES - 1 && r_size[a] < SIZE_W'(1)) begin
                eff[a] = NW'(1);
            end else if (a != NUM_AXES - 1 && r_size[a] < SIZE_W'(2)) begin
                eff[a] = NW'(2);
            end else if (32'(r_size[a]) > AXIS_POINTS) begin
                eff[a] = NW'(AXIS_POINTS);
            end else begin
                eff[a] = NW'(r_size[a]);
            end
        end
    end

    assign n_cur  = eff[r_axis];
    assign v_cur  = $signed(r_coord[r_axis]);
    assign accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign ax_we  = accept && i_req.command == CMD_AXIS_WR &&
                    32'(i_req.address) < AXIS_POINTS;
    assign tbl_we = accept && i_req.command == CMD_TABLE_WR &&
                    32'(i_req.address) < TABLE_DEPTH;
    assign ax_waddr = AXW'(32'(i_req.axis_select) * AXIS_POINTS + 32'(i_req.address));
    assign ax_raddr = AXW'(32'(r_axis) * AXIS_POINTS + 32'(n_pidx));

    always_ff @(posedge i_clk) begin
        if (ax_we) begin
            ax_mem[ax_waddr] <= i_req.write_value;
        end
        r_ax_rd <= ax_mem[ax_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            tbl_mem[TW'(i_req.address)] <= i_req.write_value;
        end
        r_tbl_rd <= tbl_mem[tbl_raddr];
    end

    assign srch_stop = ($signed(r_ax_rd) >= v_cur) || (r_pidx == n_cur - 1'b1);

    always_comb begin
        n_pidx = r_pidx;
        case (r_state)
            S_AX_INIT: n_pidx = '0;
            S_AX_LO:   n_pidx = n_cur - 1'b1;
            S_AX_HI:   n_pidx = NW'(1);
            S_AX_SRCH: n_pidx = srch_stop ? r_pidx : r_pidx + 1'b1;
            default:   n_pidx = r_pidx;
        endcase
    end

    assign d_w   = $signed({r_hi[VAL_W-1], r_hi}) - $signed({r_prev[VAL_W-1], r_prev});
    assign off_w = $signed({v_cur[VAL_W-1], v_cur}) - $signed({r_prev[VAL_W-1], r_prev});
    assign div_start = (r_state == S_DIV_SET) && !(d_w[VAL_W] || d_w == '0) &&
                       !off_w[VAL_W] && (off_w < d_w);

    qti_wdiv u_wdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (off_w),
        .i_den   (d_w),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_comb begin
        m_a = r_base;
        m_b = eff[3];
        case (r_state)
            S_IX0: begin
                m_a = IW'(r_cell[0]);
                m_b = eff[1];
            end
            S_IX1: begin
                m_a = r_base;
                m_b = eff[2];
            end
            S_IX2: begin
                m_a = r_base;
                m_b = eff[3];
            end
            S_IX3: begin
                m_a = IW'(eff[2]);
                m_b = eff[3];
            end
            S_IX4: begin
                m_a = r_sc;
                m_b = eff[1];
            end
            default: begin
                m_a = r_base;
                m_b = eff[3];
            end
        endcase
    end

    assign m_p = IW'(m_a * m_b);

    assign fidx = r_base + (r_fc[0] ? r_sg : '0) + (r_fc[1] ? r_sc : '0) +
                  (r_fc[2] ? IW'(eff[3]) : '0) +
                  IW'(r_fc[3] && eff[3] >= NW'(2));
    assign tbl_raddr = TW'(fidx);

    assign wsel = (r_bcnt < 4'd8) ? 2'd0 : (r_bcnt < 4'd12) ? 2'd1 :
                  (r_bcnt < 4'd14) ? 2'd2 : 2'd3;
    assign bl_start = (r_state == S_BL_GO);

    qti_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (bl_start),
        .i_lo    (r_cq[0]),
        .i_hi    (r_cq[1]),
        .i_wgt   (r_w[wsel]),
        .o_done  (bl_done),
        .o_res   (bl_res)
    );

    always_ff @(posedge i_clk) begin
        r_pidx <= n_pidx;
        if (accept) begin
            r_coord[0] <= i_req.coord_z;
            r_coord[1] <= i_req.coord_gz;
            r_coord[2] <= i_req.coord_c;
            r_coord[3] <= i_req.coord_k;
            r_pres <= '0;
            r_pst  <= ((i_req.command == CMD_AXIS_WR) && !ax_we) ||
                      ((i_req.command == CMD_TABLE_WR) && !tbl_we);
        end
        if (r_fv) begin
            r_cq[r_fdly] <= r_foor ? '0 : r_tbl_rd;
        end
        r_fdly <= r_fc[3:0];
        r_foor <= 64'(fidx) >= 64'(TABLE_DEPTH);
        if (r_state == S_BL_WAIT && bl_done) begin
            for (int i = 0; i < 16; i++) begin
                if (i == 14 - int'(r_bcnt)) begin
                    r_cq[i] <= bl_res;
                end else if (i < 14) begin
                    r_cq[i] <= r_cq[i + 2];
                end
            end
            r_pres <= bl_res;
        end
        case (r_state)
            S_AX_LO: r_prev <= r_ax_rd;
            S_AX_SRCH: begin
                if (srch_stop) begin
                    r_hi <= r_ax_rd;
                end else begin
                    r_prev <= r_ax_rd;
                end
            end
            S_IX0: r_base <= m_p + IW'(r_cell[1]);
            S_IX1: r_base <= m_p + IW'(r_cell[2]);
            S_IX2: r_base <= m_p + IW'(r_cell[3]);
            S_IX3: r_sc <= m_p;
            S_IX4: r_sg <= m_p;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size[0] <= SIZE_W'(2);
            r_size[1] <= SIZE_W'(2);
            r_size[2] <= SIZE_W'(2);
            r_size[3] <= SIZE_W'(1);
            r_axis <= '0;
            r_fc   <= '0;
            r_fv   <= 1'b0;
            r_bcnt <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SIZE_Z:  r_size[0] <= i_cfg_data;
                    REG_SIZE_GZ: r_size[1] <= i_cfg_data;
                    REG_SIZE_C:  r_size[2] <= i_cfg_data;
                    REG_SIZE_K:  r_size[3] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_ov && o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            r_fv <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_axis  <= '0;
                        r_state <= (i_req.command == CMD_QUERY) ? S_AX_INIT : S_DONE;
                    end
                end
                S_AX_INIT: begin
                    if (n_cur <= NW'(1)) begin
                        r_cell[r_axis] <= '0;
                        r_w[r_axis]    <= '0;
                        r_state <= S_IX0;
                    end else begin
                        r_state <= S_AX_LO;
                    end
                end
                S_AX_LO: begin
                    if (v_cur <= $signed(r_ax_rd)) begin
                        r_cell[r_axis] <= '0;
                        r_w[r_axis]    <= '0;
                        r_axis  <= r_axis + 1'b1;
                        r_state <= (r_axis == 2'd3) ? S_IX0 : S_AX_INIT;
                    end else begin
                        r_state <= S_AX_HI;
                    end
                end
                S_AX_HI: begin
                    if (v_cur >= $signed(r_ax_rd)) begin
                        r_cell[r_axis] <= n_cur - NW'(2);
                        r_w[r_axis]    <= WEIGHT_ONE;
                        r_axis  <= r_axis + 1'b1;
                        r_state <= (r_axis == 2'd3) ? S_IX0 : S_AX_INIT;
                    end else begin
                        r_state <= S_AX_SRCH;
                    end
                end
                S_AX_SRCH: begin
                    if (srch_stop) begin
                        r_cell[r_axis] <= r_pidx - 1'b1;
                        r_state <= S_DIV_SET;
                    end
                end
                S_DIV_SET: begin
                    if (div_start) begin
                        r_state <= S_DIV_WAIT;
                    end else begin
                        r_w[r_axis] <= (d_w[VAL_W] || d_w == '0 || off_w[VAL_W]) ?
                                       '0 : WEIGHT_ONE;
                        r_axis  <= r_axis + 1'b1;
                        r_state <= (r_axis == 2'd3) ? S_IX0 : S_AX_INIT;
                    end
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_w[r_axis] <= {1'b0, div_q};
                        r_axis  <= r_axis + 1'b1;
                        r_state <= (r_axis == 2'd3) ? S_IX0 : S_AX_INIT;
                    end
                end
                S_IX0: r_state <= S_IX1;
                S_IX1: r_state <= S_IX2;
                S_IX2: r_state <= S_IX3;
                S_IX3: r_state <= S_IX4;
                S_IX4: begin
                    r_fc    <= '0;
                    r_state <= S_FILL;
                end
                S_FILL: begin
                    if (r_fc == 5'd16) begin
                        r_bcnt  <= '0;
                        r_state <= S_BL_GO;
                    end else begin
                        r_fv <= 1'b1;
                        r_fc <= r_fc + 1'b1;
                    end
                end
                S_BL_GO: r_state <= S_BL_WAIT;
                S_BL_WAIT: begin
                    if (bl_done) begin
                        r_bcnt  <= r_bcnt + 1'b1;
                        r_state <= (r_bcnt == 4'd14) ? S_DONE : S_BL_GO;
                    end
                end
                S_DONE: begin
                    if (!r_ov || o_rsp.ready) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ov || o_rsp.ready)) begin
            r_ores <= r_pres;
            r_ost  <= r_pst;
        end
    end

    assign o_rsp.valid        = r_ov;
    assign o_rsp.result_value = r_ores;
    assign o_rsp.status       = r_ost;
endmodule
`default_nettype wire

>>> rtl/qti_wdiv.sv
`timescale 1ns / 1ps
`default_nettype none
module qti_wdiv (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [qti_pkg::VAL_W:0]       i_num,
    input  wire [qti_pkg::VAL_W:0]       i_den,
    output logic                         o_done,
    output logic [qti_pkg::FRAC_W-1:0]   o_quot
);
    import qti_pkg::*;

    localparam int CNT_W = $clog2(FRAC_W);

    logic             r_busy;
    logic             r_done;
    logic [VAL_W+1:0] r_rem;
    logic [VAL_W:0]   r_den;
    logic [FRAC_W-1:0] r_quot;
    logic [CNT_W-1:0] r_cnt;
    logic [VAL_W+1:0] shifted;
    logic             fits;

    // One quotient bit per cycle; the numerator is below the divisor.
    assign shifted = {r_rem[VAL_W:0], 1'b0};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FRAC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? (shifted - {1'b0, r_den}) : shifted;
            r_quot <= {r_quot[FRAC_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

>>> rtl/qti_blend.sv
`timescale 1ns / 1ps
`default_nettype none
module qti_blend (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire [qti_pkg::VAL_W-1:0]    i_lo,
    input  wire [qti_pkg::VAL_W-1:0]    i_hi,
    input  wire [qti_pkg::WGT_W-1:0]    i_wgt,
    output logic                        o_done,
    output logic [qti_pkg::VAL_W-1:0]   o_res
);
    import qti_pkg::*;

    localparam int PROD_W = VAL_W + 1 + WGT_W + 1;

    logic                     r_stage;
    logic                     r_done;
    logic signed [PROD_W-1:0] r_prod;
    logic [VAL_W-1:0]         r_lo;
    logic [VAL_W-1:0]         r_res;
    logic signed [VAL_W:0]    diff;

    // lo * (1 - w) + hi * w is lo + (hi - lo) * w, with a floor shift.
    assign diff = $signed({i_hi[VAL_W-1], i_hi}) - $signed({i_lo[VAL_W-1], i_lo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= i_start;
            r_done  <= r_stage;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PROD_W'(diff * $signed({1'b0, i_wgt}));
            r_lo   <= i_lo;
        end
        if (r_stage) begin
            r_res <= r_lo + r_prod[FRAC_W+VAL_W-1:FRAC_W];
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import qti_pkg::*;

    localparam int AXIS_POINTS = 64;
    localparam int TABLE_DEPTH = 4096;
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [AXSEL_W-1:0] axsel;
        logic [ADDR_W-1:0]  addr;
        logic signed [31:0] wval;
        logic signed [31:0] coord [4];
    } request_t;

    typedef struct {
        logic signed [31:0] value;
        logic               status;
    } response_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [SIZE_W-1:0]    cfg_data = '0;

    qti_req_if req_ch ();
    qti_rsp_if rsp_ch ();

    quadrilinear_table_interpolator #(
        .AXIS_POINTS(AXIS_POINTS),
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the block used to predict responses.
    logic signed [31:0] axis_pts [4][AXIS_POINTS];
    logic signed [31:0] lut [TABLE_DEPTH];
    int                 size_reg [4] = '{2, 2, 2, 1};

    // Axis contents as the stimulus generator expects them to be.
    logic signed [31:0] plan_axis [4][AXIS_POINTS];

    request_t  pending [$];
    response_t expected_rsp [$];
    request_t  cur;
    bit        calm = 1'b0;
    int        failures = 0;
    int        n_query = 0, n_write = 0, n_reject = 0, n_nop = 0, n_checked = 0;

    function automatic int eff_size(int ax);
        int lo;
        lo = (ax == 3) ? 1 : 2;
        if (size_reg[ax] < lo) return lo;
        if (size_reg[ax] > AXIS_POINTS) return AXIS_POINTS;
        return size_reg[ax];
    endfunction

    function automatic void bracket(input int ax, input int n, input logic signed [31:0] v,
                                    output int seg, output longint w);
        longint d, off;
        int     j;
        seg = 0;
        w = 0;
        if (n <= 1 || v <= axis_pts[ax][0]) return;
        if (v >= axis_pts[ax][n-1]) begin
            seg = n - 2;
            w = 65536;
            return;
        end
        j = 1;
        while (j < n - 1 && axis_pts[ax][j] < v) j++;
        seg = j - 1;
        d = longint'(axis_pts[ax][j]) - longint'(axis_pts[ax][j-1]);
        off = longint'(v) - longint'(axis_pts[ax][j-1]);
        if (d <= 0 || off < 0) return;
        if (off > d) off = d;
        w = (off << 16) / d;
    endfunction

    function automatic logic signed [31:0] mix(logic signed [31:0] lo, logic signed [31:0] hi,
                                               longint w);
        longint s;
        s = longint'(lo) * (65536 - w) + longint'(hi) * w;
        return 32'(s >>> 16);
    endfunction

    function automatic logic signed [31:0] interpolate(request_t r);
        int                 n [4];
        int                 seg [4];
        longint             w [4];
        longint             idx;
        int                 kk;
        logic signed [31:0] c [16];
        for (int a = 0; a < 4; a++) begin
            n[a] = eff_size(a);
            bracket(a, n[a], r.coord[a], seg[a], w[a]);
        end
        for (int i = 0; i < 16; i++) begin
            kk = (i[3] && n[3] >= 2) ? seg[3] + 1 : seg[3];
            idx = ((longint'(seg[0] + i[0]) * n[1] + (seg[1] + i[1])) * n[2]
                   + (seg[2] + i[2])) * n[3] + kk;
            c[i] = (idx >= TABLE_DEPTH) ? 32'sd0 : lut[idx];
        end
        for (int i = 0; i < 8; i++) c[i] = mix(c[2*i], c[2*i+1], w[0]);
        for (int i = 0; i < 4; i++) c[i] = mix(c[2*i], c[2*i+1], w[1]);
        for (int i = 0; i < 2; i++) c[i] = mix(c[2*i], c[2*i+1], w[2]);
        return mix(c[0], c[1], w[3]);
    endfunction

    function automatic void predict_response(request_t r);
        response_t e;
        e.value = '0;
        e.status = 1'b0;
        case (r.cmd)
            CMD_AXIS_WR: begin
                if (r.addr < AXIS_POINTS) begin
                    axis_pts[r.axsel][r.addr] = r.wval;
                    n_write++;
                end else begin
                    e.status = 1'b1;
                    n_reject++;
                end
            end
            CMD_TABLE_WR: begin
                if (r.addr < TABLE_DEPTH) begin
                    lut[r.addr] = r.wval;
                    n_write++;
                end else begin
                    e.status = 1'b1;
                    n_reject++;
                end
            end
            CMD_QUERY: begin
                e.value = interpolate(r);
                n_query++;
            end
            default: n_nop++;
        endcase
        expected_rsp.push_back(e);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) predict_response(cur);
            if (!req_ch.valid || req_ch.ready) begin
                if (pending.size() > 0 && (calm || $urandom_range(0, 99) >= 22)) begin
                    cur = pending.pop_front();
                    req_ch.command     <= cur.cmd;
                    req_ch.axis_select <= cur.axsel;
                    req_ch.address     <= cur.addr;
                    req_ch.write_value <= cur.wval;
                    req_ch.coord_z     <= cur.coord[0];
                    req_ch.coord_gz    <= cur.coord[1];
                    req_ch.coord_c     <= cur.coord[2];
                    req_ch.coord_k     <= cur.coord[3];
                    req_ch.valid       <= 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        response_t e;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsp.size() == 0) begin
                    $error("Response with no request outstanding: value %0d status %0d",
                           rsp_ch.result_value, rsp_ch.status);
                    failures++;
                end else begin
                    e = expected_rsp.pop_front();
                    n_checked++;
                    if (rsp_ch.result_value !== e.value) begin
                        $error("result_value: expected %0d, actual %0d",
                               e.value, rsp_ch.result_value);
                        failures++;
                    end
                    if (rsp_ch.status !== e.status) begin
                        $error("status: expected %0d, actual %0d", e.status, rsp_ch.status);
                        failures++;
                    end
                end
            end
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 22);
        end
    end

    function automatic request_t blank_request(logic [CMD_W-1:0] cmd);
        request_t r;
        r.cmd = cmd;
        r.axsel = 2'($urandom);
        r.addr = 12'($urandom);
        r.wval = $urandom;
        for (int a = 0; a < 4; a++) r.coord[a] = $urandom;
        return r;
    endfunction

    task automatic push_axis_write(int ax, int p, logic signed [31:0] v);
        request_t r;
        r = blank_request(CMD_AXIS_WR);
        r.axsel = 2'(ax);
        r.addr = 12'(p);
        r.wval = v;
        if (p < AXIS_POINTS) plan_axis[ax][p] = v;
        pending.push_back(r);
    endtask

    task automatic push_table_write(int adr, logic signed [31:0] v);
        request_t r;
        r = blank_request(CMD_TABLE_WR);
        r.addr = 12'(adr);
        r.wval = v;
        pending.push_back(r);
    endtask

    task automatic fill_phase(int first);
        logic signed [31:0] v;
        int                 cells;
        cells = 1;
        for (int a = 0; a < 4; a++) begin
            cells *= eff_size(a);
            v = $signed(32'($urandom_range(0, 1 << 20))) - (1 << 19);
            for (int p = 0; p < eff_size(a); p++) begin
                push_axis_write(a, p, v);
                if ($urandom_range(0, 5) != 0) v += $urandom_range(1, 1 << 18);
            end
        end
        if (cells > TABLE_DEPTH) cells = TABLE_DEPTH;
        for (int i = first; i < cells; i++) push_table_write(i, $urandom);
    endtask

    function automatic logic signed [31:0] pick_coord(int ax);
        int                 n;
        longint             lo, hi;
        n = eff_size(ax);
        lo = plan_axis[ax][0];
        hi = plan_axis[ax][n-1];
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'(lo);
            2: return 32'(hi);
            3: return plan_axis[ax][$urandom_range(0, n - 1)];
            4: return 32'(lo - $urandom_range(1, 1000));
            5: return 32'(hi + $urandom_range(1, 1000));
            default: begin
                if (hi <= lo) return 32'(lo);
                return 32'(lo + longint'({$urandom, $urandom} % (hi - lo + 1)));
            end
        endcase
    endfunction

    task automatic push_query();
        request_t r;
        r = blank_request(CMD_QUERY);
        for (int a = 0; a < 4; a++) r.coord[a] = pick_coord(a);
        pending.push_back(r);
    endtask

    // Sizes 64, 2, 64, 1: the Z coordinate stays above point 31, so every corner sits
    // in the last loaded row or falls past the table.
    task automatic push_high_query();
        request_t r;
        longint   lo, hi;
        r = blank_request(CMD_QUERY);
        for (int a = 1; a < 4; a++) r.coord[a] = pick_coord(a);
        lo = plan_axis[0][31];
        hi = plan_axis[0][AXIS_POINTS - 1];
        r.coord[0] = 32'(lo + 1 + longint'({$urandom, $urandom} % (hi - lo + 1000)));
        pending.push_back(r);
    endtask

    task automatic push_random(int count);
        int       roll;
        request_t r;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 72) begin
                push_query();
            end else if (roll < 84) begin
                push_table_write($urandom_range(0, TABLE_DEPTH - 1), $urandom);
            end else if (roll < 89) begin
                push_axis_write($urandom_range(0, 3), $urandom_range(0, AXIS_POINTS - 1),
                                $urandom);
            end else if (roll < 95) begin
                push_axis_write($urandom_range(0, 3),
                                $urandom_range(AXIS_POINTS, (1 << ADDR_W) - 1), $urandom);
            end else begin
                r = blank_request(CMD_NOP);
                pending.push_back(r);
            end
        end
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending.size() != 0 || req_ch.valid || expected_rsp.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_size(logic [CFG_IDX_W-1:0] idx, int value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= SIZE_W'(value);
        size_reg[idx] = value & 7'h7f;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_sizes(int z, int g, int c, int k);
        write_size(REG_SIZE_Z, z);
        write_size(REG_SIZE_GZ, g);
        write_size(REG_SIZE_C, c);
        write_size(REG_SIZE_K, k);
    endtask

    initial begin
        request_t r;
        req_ch.valid = 1'b0;
        req_ch.command = CMD_NOP;
        req_ch.axis_select = '0;
        req_ch.address = '0;
        req_ch.write_value = '0;
        req_ch.coord_z = '0;
        req_ch.coord_gz = '0;
        req_ch.coord_c = '0;
        req_ch.coord_k = '0;
        rsp_ch.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset sizes: a 2x2x2 table with a single-slice fourth axis.
        fill_phase(0);
        push_axis_write(0, 0, 32'sh8000_0000);
        push_axis_write(0, 1, 32'sh7fff_ffff);
        push_table_write(TABLE_DEPTH - 1, 32'sh8000_0000);
        push_table_write(0, 32'sh7fff_ffff);
        push_table_write(1, 32'sh8000_0000);
        for (int i = 0; i < 4; i++) begin
            r = blank_request(CMD_QUERY);
            for (int a = 0; a < 4; a++) begin
                case (i)
                    0: r.coord[a] = 32'sh8000_0000;
                    1: r.coord[a] = 32'sh7fff_ffff;
                    2: r.coord[a] = plan_axis[a][0];
                    default: r.coord[a] = plan_axis[a][eff_size(a) - 1];
                endcase
            end
            pending.push_back(r);
        end
        r = blank_request(CMD_QUERY);
        r.coord[0] = 32'sh0000_0001;
        pending.push_back(r);
        push_axis_write(2, AXIS_POINTS, $urandom);
        push_axis_write(3, (1 << ADDR_W) - 1, $urandom);
        r = blank_request(CMD_NOP);
        pending.push_back(r);
        for (int i = 0; i < 8; i++) push_query();
        push_random(100);
        wait_drained();

        set_sizes(3, 2, 4, 2);
        fill_phase(0);
        push_random(150);
        wait_drained();

        // Out-of-range register values clamp to 64, 2, 64, 1. Only the last table row
        // below the store limit is loaded; corners past it read as zero.
        calm = 1'b1;
        set_sizes(127, 1, 127, 0);
        fill_phase(TABLE_DEPTH - 128);
        for (int i = 0; i < 60; i++) push_high_query();
        push_axis_write(1, AXIS_POINTS + 3, $urandom);
        r = blank_request(CMD_NOP);
        pending.push_back(r);
        wait_drained();
        calm = 1'b0;

        set_sizes(5, 3, 2, 3);
        fill_phase(0);
        push_random(100);
        wait_drained();

        repeat (50) @(posedge i_clk);
        $display("Checked %0d responses: %0d queries, %0d writes, %0d rejected writes, %0d no-ops.",
                 n_checked, n_query, n_write, n_reject, n_nop);
        $display("Four size settings, clamped register values and corners past the table.");
        if (failures == 0) begin
            $display("quadrilinear_table_interpolator test passed");
        end else begin
            $display("quadrilinear_table_interpolator test failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("quadrilinear_table_interpolator test failed");
        $finish;
    end

endmodule

>>> quadrilinear_table_interpolator.f
rtl/qti_pkg.sv
rtl/qti_req_if.sv
rtl/qti_rsp_if.sv
rtl/qti_wdiv.sv
rtl/qti_blend.sv
rtl/quadrilinear_table_interpolator.sv
tb/testbench.sv
